// ===== hw/rtl/fixed_pool_free_list_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed pool allocator
// Shorthand for the clocked, reset-qualified properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_POOL_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_POOL_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define FPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks across reset.
`define FPA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and codes of the fixed pool free list allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int POOL_SIZE_DEF = 32;
  localparam int CMD_W         = 2;
  localparam int NUM_W         = 5;
  localparam int STATUS_W      = 2;

  // command codes (code 3 behaves as find)
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [NUM_W-1:0] entry_number;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    result_entry;
    logic                found;
  } rsp_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_FGET,
    S_WALK,
    S_FPUSH,
    S_DONE
  } fsm_t;

endpackage

// ===== hw/rtl/fpa_ram.sv =====
// ----------------------------------------------------------------------------
// fpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fpa_ram #(
  parameter int WIDTH = $clog2(fpa_pkg::POOL_SIZE_DEF + 1),
  parameter int DEPTH = fpa_pkg::POOL_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fixed_pool_free_list_allocator.sv =====
// Path, request accept to response valid: find and rejected requests go through S_DONE,
//   allocate through S_ALLOC and S_DONE, free of a live entry through S_FGET, S_WALK while
//   the entry is not at the head (one link per cycle from the link RAM), S_FPUSH and S_DONE.
// Requests: one at a time; the next is taken once the response is parked in the output
//   register.
// Reset: synchronous, active high; an S_INIT pass then chains the link RAM.
// ----------------------------------------------------------------------------
// fixed_pool_free_list_allocator
// Pool of entries kept as a free list and an active list in one link RAM.
// ----------------------------------------------------------------------------
module fixed_pool_free_list_allocator #(
  parameter int POOL_SIZE = fpa_pkg::POOL_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  fpa_pkg::req_t req,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output fpa_pkg::rsp_t rsp
);

  // Links hold an entry index or the null value POOL_SIZE.
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam int IW = $clog2(POOL_SIZE);
  localparam logic [LW-1:0] LINK_NULL = LW'(POOL_SIZE);
  localparam logic [IW-1:0] LAST_IDX  = IW'(POOL_SIZE - 1);

  fpa_pkg::fsm_t state, state_next;

  logic [LW-1:0]       free_head;
  logic [LW-1:0]       active_head;
  logic [POOL_SIZE-1:0] in_use;
  logic [IW-1:0]       init_cnt;
  logic [IW-1:0]       ent;        // entry being freed
  logic [fpa_pkg::NUM_W-1:0] echo; // request number, echoed in the response
  logic [LW-1:0]       ent_link;   // link out of the entry being freed
  logic [LW-1:0]       cur;        // walk pointer
  logic [IW-1:0]       steps;
  fpa_pkg::rsp_t       res;        // result waiting for the output register

  // link RAM port
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata;

  fpa_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_SIZE)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request decode. Numbers at or above POOL_SIZE are never active.
  logic          accept;
  logic          num_in_range;
  logic [IW-1:0] num_idx;
  logic          num_active;
  logic          pool_empty;
  logic          is_alloc;
  logic          is_free;
  logic          head_is_ent;
  logic          link_hit;     // walk found the predecessor
  logic          walk_end;     // walk ran off the list or out of steps
  logic          out_free;     // output register can take a result

  assign accept       = req_valid && req_ready;
  assign num_in_range = 32'(req.entry_number) < 32'(POOL_SIZE);
  assign num_idx      = IW'(req.entry_number);
  assign num_active   = num_in_range && in_use[num_idx];
  assign pool_empty   = free_head == LINK_NULL;
  assign is_alloc     = req.cmd == fpa_pkg::CMD_ALLOC;
  assign is_free      = req.cmd == fpa_pkg::CMD_FREE;
  assign head_is_ent  = active_head == LW'(ent);
  assign link_hit     = ram_rdata == LW'(ent);
  assign walk_end     = (steps == LAST_IDX) || (ram_rdata >= LINK_NULL);
  assign out_free     = !rsp_valid || rsp_ready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpa_pkg::S_INIT: begin
        if (init_cnt == LAST_IDX) state_next = fpa_pkg::S_IDLE;
      end
      fpa_pkg::S_IDLE: begin
        if (req_valid) begin
          if (is_alloc && !pool_empty)  state_next = fpa_pkg::S_ALLOC;
          else if (is_free && num_active) state_next = fpa_pkg::S_FGET;
          else                          state_next = fpa_pkg::S_DONE;
        end
      end
      fpa_pkg::S_ALLOC: state_next = fpa_pkg::S_DONE;
      fpa_pkg::S_FGET: begin
        // entry at the head, or an empty list (cannot happen for a live entry)
        if (head_is_ent || active_head >= LINK_NULL) state_next = fpa_pkg::S_FPUSH;
        else                                         state_next = fpa_pkg::S_WALK;
      end
      fpa_pkg::S_WALK: begin
        if (link_hit || walk_end) state_next = fpa_pkg::S_FPUSH;
      end
      fpa_pkg::S_FPUSH: state_next = fpa_pkg::S_DONE;
      fpa_pkg::S_DONE: begin
        if (out_free) state_next = fpa_pkg::S_IDLE;
      end
      default: state_next = fpa_pkg::S_INIT;
    endcase
  end

  // ------------------------------------------------------------ control outputs
  always_comb begin
    req_ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      fpa_pkg::S_INIT: begin
        // chain entry i to i+1; the last one lands on null
        ram_we    = 1'b1;
        ram_waddr = init_cnt;
        ram_wdata = LW'(init_cnt) + LW'(1);
      end
      fpa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        ram_raddr = is_alloc ? IW'(free_head) : num_idx;
      end
      fpa_pkg::S_ALLOC: begin
        // popped entry now points at the old active head
        ram_we    = 1'b1;
        ram_waddr = IW'(free_head);
        ram_wdata = active_head;
      end
      fpa_pkg::S_FGET: begin
        ram_raddr = IW'(active_head);
      end
      fpa_pkg::S_WALK: begin
        if (link_hit) begin
          // bypass the freed entry
          ram_we    = 1'b1;
          ram_waddr = IW'(cur);
          ram_wdata = ent_link;
        end else begin
          ram_raddr = IW'(ram_rdata);
        end
      end
      fpa_pkg::S_FPUSH: begin
        ram_we    = 1'b1;
        ram_waddr = ent;
        ram_wdata = free_head;
      end
      fpa_pkg::S_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------------ control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fpa_pkg::S_INIT;
      init_cnt    <= '0;
      free_head   <= '0;
      active_head <= LINK_NULL;
      in_use      <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (state == fpa_pkg::S_INIT) begin
        init_cnt <= init_cnt + IW'(1);
      end

      if (state == fpa_pkg::S_ALLOC) begin
        free_head           <= ram_rdata;
        active_head         <= free_head;
        in_use[IW'(free_head)] <= 1'b1;
      end

      if (state == fpa_pkg::S_FGET && head_is_ent) begin
        active_head <= ram_rdata;
      end

      if (state == fpa_pkg::S_FPUSH) begin
        free_head   <= LW'(ent);
        in_use[ent] <= 1'b0;
      end

      if (state == fpa_pkg::S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      ent  <= num_idx;
      echo <= req.entry_number;
      if (is_alloc) begin
        res.status       <= pool_empty ? fpa_pkg::ST_EMPTY : fpa_pkg::ST_OK;
        res.result_entry <= '0;
        res.found        <= 1'b0;
      end else if (is_free) begin
        res.status       <= num_active ? fpa_pkg::ST_OK : fpa_pkg::ST_NOT_ACTIVE;
        res.result_entry <= req.entry_number;
        res.found        <= 1'b0;
      end else begin
        res.status       <= fpa_pkg::ST_OK;
        res.result_entry <= req.entry_number;
        res.found        <= num_active;
      end
    end

    if (state == fpa_pkg::S_ALLOC) begin
      res.result_entry <= fpa_pkg::NUM_W'(free_head);
      res.found        <= 1'b1;
    end

    if (state == fpa_pkg::S_FGET) begin
      ent_link <= ram_rdata;
      cur      <= active_head;
      steps    <= '0;
    end

    if (state == fpa_pkg::S_WALK) begin
      cur   <= ram_rdata;
      steps <= steps + IW'(1);
    end

    if (state == fpa_pkg::S_FPUSH) begin
      res.result_entry <= echo;
    end

    if (state == fpa_pkg::S_DONE && out_free) begin
      rsp <= res;
    end
  end

endmodule

// ===== hw/rtl/fpa_checker.sv =====
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks of the fixed pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_pool_free_list_allocator_defines.svh"

module fpa_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input fpa_pkg::rsp_t rsp
);

  logic req_fire;
  logic rsp_stall;
  logic rsp_empty;
  logic rsp_reject;
  logic rsp_zero;
  assign req_fire   = req_valid && req_ready;
  assign rsp_stall  = rsp_valid && !rsp_ready;
  assign rsp_empty  = rsp_valid && rsp.status == fpa_pkg::ST_EMPTY;
  assign rsp_reject = rsp_valid && rsp.status == fpa_pkg::ST_NOT_ACTIVE;
  assign rsp_zero   = rsp.result_entry == '0 && !rsp.found;

  // no response is left standing once reset has been seen
  `FPA_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clk, rst, !rsp_valid, "rsp_valid after reset")

  // one request at a time
  `FPA_ASSERT_NEXT(a_one_in_flight, clk, rst, req_fire, !req_ready, "request taken while busy")

  // stalled response holds
  `FPA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_stall, rsp_valid && $stable(rsp), "rsp not held")

  // empty pool reports entry zero and not found
  `FPA_ASSERT_NOW(a_empty_rsp, clk, rst, rsp_empty, rsp_zero, "bad empty-pool response")

  // a rejected free never reports the entry as found
  `FPA_ASSERT_NOW(a_reject_rsp, clk, rst, rsp_reject, !rsp.found, "bad reject response")

endmodule

bind fixed_pool_free_list_allocator fpa_checker u_fpa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
